[sv/jdn_pkg.sv]
// shared widths, constants, reciprocal multipliers, tables and result types for the converter
`timescale 1ns / 1ps
package jdn_pkg;

	// field widths
	localparam int unsigned DAY_W    = 6;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned JDN_W    = 23;
	localparam int unsigned ODAY_W   = 7;
	localparam int unsigned OMONTH_W = 5;
	localparam int unsigned OYEAR_W  = 15;

	// op codes
	localparam logic OP_DATE2NUM = 1'b0;
	localparam logic OP_NUM2DATE = 1'b1;

	// pipeline depth of both conversion paths (they must line up)
	localparam int unsigned PIPE_DEPTH  = 10;
	localparam int unsigned DATE_STAGES = 5;
	localparam int unsigned PAD_DEPTH   = PIPE_DEPTH - DATE_STAGES;

	// calendar constants
	localparam int unsigned EPOCH         = 1721119;
	localparam int unsigned CENTURY_DAYS  = 146097;
	localparam int unsigned QUAD_DAYS     = 1461;
	localparam int unsigned MONTH_SPAN    = 153;
	localparam int unsigned YEARS_PER_CEN = 100;
	localparam int unsigned MONTH_DIG     = 5;

	// exact reciprocals: floor(n / D) = (n * ceil(2^K / D)) >> K for n < 2^(K - ceil(log2 D))
	localparam int unsigned CENT_SHIFT = 43;
	localparam logic [63:0] CENT_RECIP_W =
		((64'd1 << CENT_SHIFT) + 64'(CENTURY_DAYS) - 64'd1) / 64'(CENTURY_DAYS);
	localparam logic [25:0] CENT_RECIP = CENT_RECIP_W[25:0];

	localparam int unsigned QUAD_SHIFT = 29;
	localparam logic [63:0] QUAD_RECIP_W =
		((64'd1 << QUAD_SHIFT) + 64'(QUAD_DAYS) - 64'd1) / 64'(QUAD_DAYS);
	localparam logic [18:0] QUAD_RECIP = QUAD_RECIP_W[18:0];

	localparam int unsigned MON_SHIFT = 19;
	localparam logic [63:0] MON_RECIP_W =
		((64'd1 << MON_SHIFT) + 64'(MONTH_SPAN) - 64'd1) / 64'(MONTH_SPAN);
	localparam logic [11:0] MON_RECIP = MON_RECIP_W[11:0];

	localparam int unsigned HUND_SHIFT = 21;
	localparam logic [63:0] HUND_RECIP_W =
		((64'd1 << HUND_SHIFT) + 64'(YEARS_PER_CEN) - 64'd1) / 64'(YEARS_PER_CEN);
	localparam logic [14:0] HUND_RECIP = HUND_RECIP_W[14:0];

	localparam int unsigned FIVE_SHIFT = 11;
	localparam logic [63:0] FIVE_RECIP_W =
		((64'd1 << FIVE_SHIFT) + 64'(MONTH_DIG) - 64'd1) / 64'(MONTH_DIG);
	localparam logic [8:0] FIVE_RECIP = FIVE_RECIP_W[8:0];

	// result words of the two paths
	typedef struct packed {
		logic             valid;
		logic [JDN_W-1:0] day_number;
	} jdn_date_res_t;

	typedef struct packed {
		logic                valid;
		logic [ODAY_W-1:0]   day;
		logic [OMONTH_W-1:0] month;
		logic [OYEAR_W-1:0]  year;
	} jdn_num_res_t;

	// days in month, index 0 is the leap february
	function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] mon);
		logic [4:0] md;
		case (mon) inside
			4'd0: md = 5'd29;
			4'd2: md = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: md = 5'd30;
			default: md = 5'd31;
		endcase
		return md;
	endfunction

	// (153 * mt + 2) / 5 for a march-based month index
	function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mt);
		logic [8:0] off;
		case (mt)
			4'd0: off = 9'd0;
			4'd1: off = 9'd31;
			4'd2: off = 9'd61;
			4'd3: off = 9'd92;
			4'd4: off = 9'd122;
			4'd5: off = 9'd153;
			4'd6: off = 9'd184;
			4'd7: off = 9'd214;
			4'd8: off = 9'd245;
			4'd9: off = 9'd275;
			4'd10: off = 9'd306;
			4'd11: off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

endpackage

[sv/jdn_date2num.sv]
// date to julian day number pipeline, padded to the common pipeline depth
`timescale 1ns / 1ps
module jdn_date2num (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [jdn_pkg::DAY_W-1:0]     day,
	input  logic [jdn_pkg::MONTH_W-1:0]   month,
	input  logic [jdn_pkg::YEAR_W-1:0]    year,
	output jdn_pkg::jdn_date_res_t        res
);
	import jdn_pkg::*;

	// stage 1 logic
	logic [MONTH_W-1:0] mc_c;
	logic [4:0]         maxd_c;
	logic [DAY_W-1:0]   dc_c;
	logic [MONTH_W-1:0] mt_c;
	logic [YEAR_W-1:0]  yt_c;
	logic               zero_c;

	logic               v_s1, zero_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [8:0]         moff_s1;
	logic [YEAR_W-1:0]  yt_s1;

	logic               v_s2, zero_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [8:0]         moff_s2;
	logic [YEAR_W-1:0]  yt_s2;
	logic [28:0]        hprod_s2;

	logic [7:0]         cen_c;
	logic [YEAR_W-1:0]  yrem_c;
	logic               v_s3, zero_s3;
	logic [DAY_W-1:0]   day_s3;
	logic [8:0]         moff_s3;
	logic [7:0]         cen_s3;
	logic [6:0]         yrem_s3;

	logic [25:0]        cprod_c;
	logic [17:0]        qprod_c;
	logic               v_s4, zero_s4;
	logic [23:0]        cpart_s4;
	logic [15:0]        qpart_s4;
	logic [20:0]        base_s4;

	logic [24:0]        sum_c;
	logic               v_s5;
	logic [JDN_W-1:0]   jdn_s5;

	logic               pad_v_q [PAD_DEPTH];
	logic [JDN_W-1:0]   pad_n_q [PAD_DEPTH];

	always_comb begin
		zero_c = (day == '0) || (month == '0) || (year == '0);
		mc_c   = (month > 4'd12) ? 4'd12 : month;
		if (mc_c == 4'd2 && year[1:0] == 2'b00) begin
			maxd_c = month_days(4'd0);
		end else begin
			maxd_c = month_days(mc_c);
		end
		dc_c = (day > DAY_W'(maxd_c)) ? DAY_W'(maxd_c) : day;
		if (mc_c > 4'd2) begin
			mt_c = mc_c - 4'd3;
			yt_c = year;
		end else begin
			mt_c = mc_c + 4'd9;
			yt_c = year - YEAR_W'(1);
		end
	end

	always_comb begin
		cen_c  = hprod_s2[HUND_SHIFT +: 8];
		yrem_c = yt_s2 - (YEAR_W'(cen_c) * YEAR_W'(YEARS_PER_CEN));
		cprod_c = 26'(cen_s3) * 26'(CENTURY_DAYS);
		qprod_c = 18'(yrem_s3) * 18'(QUAD_DAYS);
		sum_c   = 25'(cpart_s4) + 25'(qpart_s4) + 25'(base_s4);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int i = 0; i < PAD_DEPTH; i++) begin
				pad_v_q[i] <= 1'b0;
			end
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			pad_v_q[0] <= v_s5;
			for (int i = 1; i < PAD_DEPTH; i++) begin
				pad_v_q[i] <= pad_v_q[i-1];
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		zero_s1 <= zero_c;
		day_s1  <= dc_c;
		moff_s1 <= month_offset(mt_c);
		yt_s1   <= yt_c;

		zero_s2  <= zero_s1;
		day_s2   <= day_s1;
		moff_s2  <= moff_s1;
		yt_s2    <= yt_s1;
		hprod_s2 <= 29'(yt_s1) * 29'(HUND_RECIP);

		zero_s3 <= zero_s2;
		day_s3  <= day_s2;
		moff_s3 <= moff_s2;
		cen_s3  <= cen_c;
		yrem_s3 <= yrem_c[6:0];

		zero_s4  <= zero_s3;
		cpart_s4 <= cprod_c[25:2];
		qpart_s4 <= qprod_c[17:2];
		base_s4  <= 21'(EPOCH) + 21'(day_s3) + 21'(moff_s3);

		jdn_s5 <= zero_s4 ? '0 : sum_c[JDN_W-1:0];

		pad_n_q[0] <= jdn_s5;
		for (int i = 1; i < PAD_DEPTH; i++) begin
			pad_n_q[i] <= pad_n_q[i-1];
		end
	end

	assign res.valid      = pad_v_q[PAD_DEPTH-1];
	assign res.day_number = pad_n_q[PAD_DEPTH-1];

endmodule

[sv/jdn_num2date.sv]
// julian day number to date pipeline, sign handled as magnitude plus sign bit
`timescale 1ns / 1ps
module jdn_num2date (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [jdn_pkg::JDN_W-1:0] day_number,
	output jdn_pkg::jdn_num_res_t     res
);
	import jdn_pkg::*;

	logic [26:0] x1_c, x1n_c;
	logic        v_s1, zero_s1, sgn1_s1;
	logic [24:0] mag1_s1;

	logic        v_s2, zero_s2, sgn1_s2;
	logic [24:0] mag1_s2;
	logic [50:0] prod1_s2;

	logic [7:0]  qa_c;
	logic [24:0] rema_c;
	logic        v_s3, zero_s3, sgn1_s3;
	logic [7:0]  qa_s3;
	logic [17:0] rema_s3;

	logic [17:0] a_c, mag2_c;
	logic        sgn2_c;
	logic [8:0]  ya_c;
	logic        v_s4, zero_s4, sgn2_s4;
	logic [17:0] mag2_s4;
	logic [8:0]  ya_s4;

	logic        v_s5, zero_s5, sgn2_s5;
	logic [17:0] mag2_s5;
	logic [8:0]  ya_s5;
	logic [36:0] prod2_s5;

	logic [6:0]  qb_c;
	logic [17:0] remb_c;
	logic        v_s6, zero_s6, sgn2_s6;
	logic [6:0]  qb_s6;
	logic [10:0] remb_s6;
	logic [8:0]  ya_s6;

	logic [11:0] x3_c, m3_c, d3_c, x4_c, x4n_c;
	logic [8:0]  q3_c;
	logic [7:0]  qs_c;
	logic        v_s7, zero_s7, sgn4_s7;
	logic [10:0] mag4_s7;
	logic [8:0]  ya_s7;
	logic [7:0]  qs_s7;

	logic        v_s8, zero_s8, sgn4_s8;
	logic [10:0] mag4_s8;
	logic [22:0] prod3_s8;
	logic [15:0] yb_s8;

	logic [3:0]  qc_c;
	logic [10:0] remc_c;
	logic        v_s9, zero_s9, sgn4_s9;
	logic [3:0]  qc_s9;
	logic [7:0]  remc_s9;
	logic [15:0] yb_s9;

	logic [4:0]  m_c, mon_c;
	logic [8:0]  d4_c, x5_c, m5_c;
	logic [16:0] p5_c;
	logic [5:0]  q5_c;
	logic [6:0]  d5_c;
	logic        ge10_c;
	logic [15:0] yr_c;
	logic        v_s10;
	logic [ODAY_W-1:0]   day_s10;
	logic [OMONTH_W-1:0] mon_s10;
	logic [OYEAR_W-1:0]  yr_s10;

	// stage 1: 4t - 1 split into sign and magnitude
	always_comb begin
		x1_c  = {2'b00, day_number, 2'b00} - 27'(4 * EPOCH + 1);
		x1n_c = 27'd0 - x1_c;
	end

	// stage 3: quotient and remainder by the century length
	always_comb begin
		qa_c   = prod1_s2[CENT_SHIFT +: 8];
		rema_c = mag1_s2 - 25'(26'(qa_c) * 26'(CENTURY_DAYS));
	end

	// stage 4: d = t / 4, then 4d + 3
	always_comb begin
		a_c = {rema_s3[17:2], 2'b00};
		if (!sgn1_s3) begin
			mag2_c = a_c + 18'd3;
			sgn2_c = 1'b0;
		end else if (a_c == '0) begin
			mag2_c = 18'd3;
			sgn2_c = 1'b0;
		end else begin
			mag2_c = a_c - 18'd3;
			sgn2_c = 1'b1;
		end
		ya_c = sgn1_s3 ? (9'd0 - {1'b0, qa_s3}) : {1'b0, qa_s3};
	end

	// stage 6: quotient and remainder by the four-year length
	always_comb begin
		qb_c   = prod2_s5[QUAD_SHIFT +: 7];
		remb_c = mag2_s5 - 18'(18'(qb_c) * 18'(QUAD_DAYS));
	end

	// stage 7: day of year, then 5d - 3
	always_comb begin
		x3_c  = sgn2_s6 ? (12'd4 - 12'(remb_s6)) : (12'(remb_s6) + 12'd4);
		m3_c  = x3_c[11] ? (12'd0 - x3_c) : x3_c;
		q3_c  = m3_c[10:2];
		d3_c  = x3_c[11] ? (12'd0 - 12'(q3_c)) : 12'(q3_c);
		x4_c  = {d3_c[9:0], 2'b00} + d3_c - 12'd3;
		x4n_c = 12'd0 - x4_c;
		qs_c  = sgn2_s6 ? (8'd0 - {1'b0, qb_s6}) : {1'b0, qb_s6};
	end

	// stage 9: quotient and remainder by the five-month span
	always_comb begin
		qc_c   = prod3_s8[MON_SHIFT +: 4];
		remc_c = mag4_s8 - 11'(11'(qc_c) * 11'(MONTH_SPAN));
	end

	// stage 10: day of month and the march-based month shift
	always_comb begin
		m_c    = sgn4_s9 ? (5'd0 - 5'(qc_s9)) : 5'(qc_s9);
		d4_c   = sgn4_s9 ? (9'd0 - 9'(remc_s9)) : 9'(remc_s9);
		x5_c   = d4_c + 9'd5;
		m5_c   = x5_c[8] ? (9'd0 - x5_c) : x5_c;
		p5_c   = 17'(m5_c[7:0]) * 17'(FIVE_RECIP);
		q5_c   = p5_c[FIVE_SHIFT +: 6];
		d5_c   = x5_c[8] ? (7'd0 - 7'(q5_c)) : 7'(q5_c);
		ge10_c = !m_c[4] && (m_c >= 5'd10);
		mon_c  = ge10_c ? (m_c - 5'd9) : (m_c + 5'd3);
		yr_c   = yb_s9 + 16'(ge10_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (day_number == '0);
		sgn1_s1 <= x1_c[26];
		mag1_s1 <= x1_c[26] ? x1n_c[24:0] : x1_c[24:0];

		zero_s2  <= zero_s1;
		sgn1_s2  <= sgn1_s1;
		mag1_s2  <= mag1_s1;
		prod1_s2 <= 51'(mag1_s1) * 51'(CENT_RECIP);

		zero_s3 <= zero_s2;
		sgn1_s3 <= sgn1_s2;
		qa_s3   <= qa_c;
		rema_s3 <= rema_c[17:0];

		zero_s4 <= zero_s3;
		sgn2_s4 <= sgn2_c;
		mag2_s4 <= mag2_c;
		ya_s4   <= ya_c;

		zero_s5  <= zero_s4;
		sgn2_s5  <= sgn2_s4;
		mag2_s5  <= mag2_s4;
		ya_s5    <= ya_s4;
		prod2_s5 <= 37'(mag2_s4) * 37'(QUAD_RECIP);

		zero_s6 <= zero_s5;
		sgn2_s6 <= sgn2_s5;
		qb_s6   <= qb_c;
		remb_s6 <= remb_c[10:0];
		ya_s6   <= ya_s5;

		zero_s7 <= zero_s6;
		sgn4_s7 <= x4_c[11];
		mag4_s7 <= x4_c[11] ? x4n_c[10:0] : x4_c[10:0];
		ya_s7   <= ya_s6;
		qs_s7   <= qs_c;

		zero_s8  <= zero_s7;
		sgn4_s8  <= sgn4_s7;
		mag4_s8  <= mag4_s7;
		prod3_s8 <= 23'(mag4_s7) * 23'(MON_RECIP);
		yb_s8    <= 16'({{7{ya_s7[8]}}, ya_s7} * 16'(YEARS_PER_CEN)) + {{8{qs_s7[7]}}, qs_s7};

		zero_s9 <= zero_s8;
		sgn4_s9 <= sgn4_s8;
		qc_s9   <= qc_c;
		remc_s9 <= remc_c[7:0];
		yb_s9   <= yb_s8;

		day_s10 <= zero_s9 ? '0 : d5_c;
		mon_s10 <= zero_s9 ? '0 : mon_c;
		yr_s10  <= zero_s9 ? '0 : yr_c[OYEAR_W-1:0];
	end

	assign res.valid = v_s10;
	assign res.day   = day_s10;
	assign res.month = mon_s10;
	assign res.year  = yr_s10;

endmodule

[sv/julian_day_number_converter_top.sv]
// top level of the gregorian date / julian day number converter
`timescale 1ns / 1ps
// Converts one word per clock between a gregorian date (day, month, year) and a julian day
// number, the direction picked per word by op (0: date to number, 1: number to date). A word
// is taken at every rising edge where start is high; busy never rises, so start may stay high
// for back to back words. Each result is held on the result ports for exactly one cycle
// with done high, in the same order as the words went in. The pipeline depth is set by the
// number to date path: a sign split, three divisions by constants (century, four-year and
// five-month lengths), each a registered reciprocal multiply followed by a registered
// remainder step, the 4d + 3 and day of year steps, the final day/month fixup and the output register here.
// The date to number path is shorter and is padded to the same depth so results never collide.
// Date input: a zero day, month or year gives number 0; months above 12 are read as 12 and
// days above the month length are clamped (february has 29 whenever the year divides by 4).
// Number input: zero gives an all-zero date; numbers before the calendar epoch come out as
// the small, zero or negative values that truncating division gives, in two's complement.
// Fields the chosen op does not produce are returned as 0.
module julian_day_number_converter_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                op,
	input  logic [jdn_pkg::DAY_W-1:0]           in_day,
	input  logic [jdn_pkg::MONTH_W-1:0]         in_month,
	input  logic [jdn_pkg::YEAR_W-1:0]          in_year,
	input  logic [jdn_pkg::JDN_W-1:0]           in_day_number,
	output logic                                done,
	output logic [jdn_pkg::JDN_W-1:0]           out_day_number,
	output logic signed [jdn_pkg::ODAY_W-1:0]   out_day,
	output logic signed [jdn_pkg::OMONTH_W-1:0] out_month,
	output logic signed [jdn_pkg::OYEAR_W-1:0]  out_year
);
	import jdn_pkg::*;

	logic          accept;
	jdn_date_res_t date_res;
	jdn_num_res_t  num_res;

	logic                done_q;
	logic [JDN_W-1:0]    dn_q;
	logic [ODAY_W-1:0]   day_q;
	logic [OMONTH_W-1:0] mon_q;
	logic [OYEAR_W-1:0]  yr_q;

	// fully pipelined, one word per cycle, nothing ever holds the input off
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// both paths see the same word, only the selected one carries a valid bit
	jdn_date2num u_date2num (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept && (op == OP_DATE2NUM)),
		.day      (in_day),
		.month    (in_month),
		.year     (in_year),
		.res      (date_res)
	);

	jdn_num2date u_num2date (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept && (op == OP_NUM2DATE)),
		.day_number (in_day_number),
		.res        (num_res)
	);

	// the two paths have equal depth, so at most one valid shows up per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= date_res.valid || num_res.valid;
		end
	end

	// merge into the output register, unused fields forced to zero
	always_ff @(posedge clk) begin
		dn_q  <= date_res.valid ? date_res.day_number : '0;
		day_q <= num_res.valid ? num_res.day : '0;
		mon_q <= num_res.valid ? num_res.month : '0;
		yr_q  <= num_res.valid ? num_res.year : '0;
	end

	assign done           = done_q;
	assign out_day_number = dn_q;
	assign out_day        = $signed(day_q);
	assign out_month      = $signed(mon_q);
	assign out_year       = $signed(yr_q);

endmodule
